// ----- src/cst_pkg.sv -----
package cst_pkg;

   // token kinds
   localparam logic [1:0] KIND_WORD   = 2'd0;
   localparam logic [1:0] KIND_SINGLE = 2'd1;
   localparam logic [1:0] KIND_PAIR   = 2'd2;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   // one result without its line number
   typedef struct packed {
      logic       valid;
      logic [7:0] token_char;
      logic       token_first;
      logic       token_last;
      logic [1:0] token_kind;
      logic       run_last;
   } cst_tok_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB) || (c == CH_NUL);
   endfunction

   function automatic logic is_delim(input logic [7:0] c);
      logic r;
      case (c)
         8'h3B, 8'h2C, 8'h2E, 8'h3A, 8'h22,
         8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D,
         8'h3E, 8'h3C, 8'h5B, 8'h5D, 8'h28, 8'h29: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic starts_pair(input logic [7:0] c);
      return (c == CH_COLON) || (c == CH_LT) || (c == CH_GT) || (c == CH_DOT);
   endfunction

   function automatic logic makes_pair(input logic [7:0] a, input logic [7:0] b);
      return ((a == CH_COLON) && (b == CH_EQ)) || ((a == CH_LT) && (b == CH_EQ)) ||
             ((a == CH_LT) && (b == CH_GT)) || ((a == CH_GT) && (b == CH_EQ)) ||
             ((a == CH_DOT) && (b == CH_DOT));
   endfunction

endpackage

// ----- src/cst_if.sv -----
interface cst_req_if (input logic clock);
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       end_of_file;

   modport source (output valid, output in_char, output end_of_file, input ready);
   modport sink   (input valid, input in_char, input end_of_file, output ready);
endinterface

interface cst_rsp_if #(parameter int LINE_BITS = 16) (input logic clock);
   logic                 valid;
   logic                 ready;
   logic [7:0]           token_char;
   logic                 token_first;
   logic                 token_last;
   logic [1:0]           token_kind;
   logic [LINE_BITS-1:0] line_number;
   logic                 run_last;

   modport source (output valid, output token_char, output token_first,
                   output token_last, output token_kind, output line_number,
                   output run_last, input ready);
   modport sink   (input valid, input token_char, input token_first,
                   input token_last, input token_kind, input line_number,
                   input run_last, output ready);
endinterface

// ----- src/cst_lexer.sv -----
module cst_lexer #(
   parameter int LINE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            in_char,
   input  logic                  end_of_file,
   output cst_pkg::cst_tok_type  tok_a,
   output cst_pkg::cst_tok_type  tok_b,
   output logic [LINE_BITS-1:0]  line_now
);
   import cst_pkg::*;

   localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
   localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

   logic [7:0]           held_char_ff, held_char_in;
   logic                 held_valid_ff, held_valid_in;
   logic                 held_first_ff, held_first_in;
   logic [7:0]           pend_char_ff, pend_char_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [LINE_BITS-1:0] line_ff, line_in;

   logic b_space, b_delim, b_word, pair, fresh, fresh_emit;

   always_comb begin
      b_space    = is_space(in_char);
      b_delim    = is_delim(in_char);
      b_word     = !b_space && !b_delim;
      pair       = !end_of_file && !held_valid_ff && pend_valid_ff &&
                   makes_pair(pend_char_ff, in_char);
      fresh      = !end_of_file && !(held_valid_ff && b_word) && !pair;
      fresh_emit = fresh && b_delim && !starts_pair(in_char);

      // tok_b is the result from the incoming byte, tok_a the one from what was held or pending
      tok_b.valid       = pair || fresh_emit;
      tok_b.token_char  = in_char;
      tok_b.token_first = !pair;
      tok_b.token_last  = 1'b1;
      tok_b.token_kind  = pair ? KIND_PAIR : KIND_SINGLE;
      tok_b.run_last    = 1'b1;

      tok_a.valid       = held_valid_ff || pend_valid_ff;
      tok_a.token_char  = held_valid_ff ? held_char_ff : pend_char_ff;
      tok_a.token_first = held_valid_ff ? held_first_ff : 1'b1;
      tok_a.token_last  = held_valid_ff ? (end_of_file || !b_word) : !pair;
      tok_a.token_kind  = held_valid_ff ? KIND_WORD : (pair ? KIND_PAIR : KIND_SINGLE);
      tok_a.run_last    = !tok_b.valid;

      line_now = line_ff;

      held_char_in  = held_char_ff;
      held_valid_in = held_valid_ff;
      held_first_in = held_first_ff;
      pend_char_in  = pend_char_ff;
      pend_valid_in = pend_valid_ff;
      line_in       = line_ff;

      if (end_of_file) begin
         held_char_in  = '0;
         held_valid_in = 1'b0;
         held_first_in = 1'b0;
         pend_char_in  = '0;
         pend_valid_in = 1'b0;
         line_in       = LINE_ONE;
      end else if (held_valid_ff && b_word) begin
         // extend the word
         held_char_in  = in_char;
         held_first_in = 1'b0;
      end else if (pair) begin
         pend_valid_in = 1'b0;
      end else begin
         held_valid_in = b_word;
         held_first_in = b_word;
         if (b_word) held_char_in = in_char;
         pend_valid_in = b_delim && starts_pair(in_char);
         if (b_delim && starts_pair(in_char)) pend_char_in = in_char;
         if ((in_char == CH_NL) && (line_ff != LINE_MAX)) line_in = line_ff + LINE_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_char_ff  <= '0;
         held_valid_ff <= 1'b0;
         held_first_ff <= 1'b0;
         pend_char_ff  <= '0;
         pend_valid_ff <= 1'b0;
         line_ff       <= LINE_ONE;
      end else if (accept) begin
         held_char_ff  <= held_char_in;
         held_valid_ff <= held_valid_in;
         held_first_ff <= held_first_in;
         pend_char_ff  <= pend_char_in;
         pend_valid_ff <= pend_valid_in;
         line_ff       <= line_in;
      end
   end

endmodule

// ----- src/cst_queue.sv -----
module cst_queue #(
   parameter int LINE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cst_pkg::cst_tok_type tok_a,
   input  cst_pkg::cst_tok_type tok_b,
   input  logic [LINE_BITS-1:0] line_now,
   output logic                 has_room,
   cst_rsp_if.source            rsp_if
);
   import cst_pkg::*;

   localparam int DEPTH = 4;

   cst_tok_type          tok_ff  [DEPTH];
   logic [LINE_BITS-1:0] line_ff [DEPTH];
   logic [1:0]           head_ff, head_in;
   logic [1:0]           tail_ff, tail_in;
   logic [2:0]           count_ff, count_in;
   logic                 push_a, push_b, pop;
   logic [1:0]           slot_b;

   always_comb begin
      push_a   = push && tok_a.valid;
      push_b   = push && tok_b.valid;
      pop      = rsp_if.valid && rsp_if.ready;
      slot_b   = tail_ff + {1'b0, push_a};
      tail_in  = slot_b + {1'b0, push_b};
      head_in  = head_ff + {1'b0, pop};
      count_in = count_ff + {2'b00, push_a} + {2'b00, push_b} - {2'b00, pop};
      has_room = count_ff <= 3'd2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (push_a) begin
         tok_ff[tail_ff]  <= tok_a;
         line_ff[tail_ff] <= line_now;
      end
      if (push_b) begin
         tok_ff[slot_b]  <= tok_b;
         line_ff[slot_b] <= line_now;
      end
   end

   assign rsp_if.valid       = count_ff != 3'd0;
   assign rsp_if.token_char  = tok_ff[head_ff].token_char;
   assign rsp_if.token_first = tok_ff[head_ff].token_first;
   assign rsp_if.token_last  = tok_ff[head_ff].token_last;
   assign rsp_if.token_kind  = tok_ff[head_ff].token_kind;
   assign rsp_if.run_last    = tok_ff[head_ff].run_last;
   assign rsp_if.line_number = line_ff[head_ff];

endmodule

// ----- src/char_stream_tokenizer.sv -----
// A result is queued as its item is taken and offered on rsp from the queue head.
// One item per cycle while req ready is high; an item giving a two-character operator
// puts two results into the four-entry result queue, which drains one result per cycle
// while rsp ready is high. req ready is high while the queue holds two results or fewer.
// Reset (synchronous, active high): empty the queue, drop held word and pending
// delimiter, line count back to one.
module char_stream_tokenizer #(
   parameter int LINE_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   cst_req_if.sink    req_if,
   cst_rsp_if.source  rsp_if
);
   import cst_pkg::*;

   cst_tok_type          tok_a;
   cst_tok_type          tok_b;
   logic [LINE_BITS-1:0] line_now;
   logic                 has_room;
   logic                 accept;

   // take an item only when both possible results fit in the queue
   assign req_if.ready = has_room;
   assign accept       = req_if.valid && has_room;

   // classify the byte against the held word / pending delimiter, advance state
   cst_lexer #(.LINE_BITS(LINE_BITS)) u_lexer (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_char     (req_if.in_char),
      .end_of_file (req_if.end_of_file),
      .tok_a       (tok_a),
      .tok_b       (tok_b),
      .line_now    (line_now)
   );

   // hold results until the sink takes them, one result per handshake
   cst_queue #(.LINE_BITS(LINE_BITS)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .tok_a    (tok_a),
      .tok_b    (tok_b),
      .line_now (line_now),
      .has_room (has_room),
      .rsp_if   (rsp_if)
   );

endmodule

// ----- src/cst_checker.sv -----
module cst_checker #(
   parameter int LINE_BITS = 16
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [7:0]           token_char,
   input logic                 token_first,
   input logic                 token_last,
   input logic [1:0]           token_kind,
   input logic [LINE_BITS-1:0] line_number
);
   import cst_pkg::*;

   // a stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(token_char) && $stable(line_number))
      else $error("rsp item changed while stalled");

   a_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> line_number != '0)
      else $error("line number zero");

   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && token_kind == KIND_SINGLE |-> token_first && token_last)
      else $error("single delimiter not first and last");

   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && token_kind == KIND_PAIR && token_first |=>
      rsp_valid && token_kind == KIND_PAIR && !token_first && token_last)
      else $error("operator second half missing");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> token_kind == KIND_WORD || token_kind == KIND_SINGLE ||
                    token_kind == KIND_PAIR)
      else $error("bad token kind");

endmodule

bind char_stream_tokenizer cst_checker #(.LINE_BITS(LINE_BITS)) u_cst_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .token_char  (rsp_if.token_char),
   .token_first (rsp_if.token_first),
   .token_last  (rsp_if.token_last),
   .token_kind  (rsp_if.token_kind),
   .line_number (rsp_if.line_number)
);

// ----- verif/cst_tokenizer_checker.sv -----
`timescale 1ns / 1ps

module cst_tokenizer_checker #(
   parameter int LINE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [7:0]           req_in_char,
   input  logic                 req_end_of_file,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [7:0]           rsp_token_char,
   input  logic                 rsp_token_first,
   input  logic                 rsp_token_last,
   input  logic [1:0]           rsp_token_kind,
   input  logic [LINE_BITS-1:0] rsp_line_number,
   input  logic                 rsp_run_last,
   output int                   mismatch_count,
   output int                   tokens_awaited,
   output int                   chars_checked
);
   import cst_pkg::*;

   typedef struct packed {
      logic [7:0]           ch;
      logic                 first;
      logic                 last;
      logic [1:0]           kind;
      logic [LINE_BITS-1:0] line;
      logic                 run_last;
   } tok_char_type;

   localparam logic [LINE_BITS-1:0] LINE_TOP   = '1;
   localparam logic [LINE_BITS-1:0] LINE_FIRST = LINE_BITS'(1);
   localparam logic [16*8-1:0]      DELIM_CHARS = ";,.:\"+-*/=><[]()";

   tok_char_type         token_q[$];
   logic [7:0]           word_char;
   logic                 word_held;
   logic                 word_first;
   logic [7:0]           op_char;
   logic                 op_held;
   logic [LINE_BITS-1:0] cur_line;
   int                   step_n;

   function automatic logic blank(input logic [7:0] c);
      case (c)
         CH_SPACE, CH_NL, CH_TAB, CH_NUL: return 1'b1;
         default:                         return 1'b0;
      endcase
   endfunction

   function automatic logic delim(input logic [7:0] c);
      for (int i = 0; i < 16; i++)
         if (DELIM_CHARS[i*8 +: 8] == c) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic opener(input logic [7:0] c);
      case (c)
         CH_COLON, CH_LT, CH_GT, CH_DOT: return 1'b1;
         default:                        return 1'b0;
      endcase
   endfunction

   function automatic logic pairs_up(input logic [7:0] a, input logic [7:0] b);
      case ({a, b})
         ":=", "<=", "<>", ">=", "..": return 1'b1;
         default:                      return 1'b0;
      endcase
   endfunction

   function automatic void put_char(input logic [7:0] c, input logic f, input logic l,
                                    input logic [1:0] k);
      tok_char_type t;
      t = '{ch: c, first: f, last: l, kind: k, line: cur_line, run_last: 1'b0};
      token_q.push_back(t);
      step_n++;
   endfunction

   // a byte seen with nothing held
   function automatic void take_byte(input logic [7:0] b);
      if (blank(b)) begin
         if (b == CH_NL && cur_line != LINE_TOP) cur_line++;
      end else if (!delim(b)) begin
         word_char  = b;
         word_held  = 1'b1;
         word_first = 1'b1;
      end else if (opener(b)) begin
         op_char = b;
         op_held = 1'b1;
      end else begin
         put_char(b, 1'b1, 1'b1, KIND_SINGLE);
      end
   endfunction

   function automatic void lex_item(input logic [7:0] b, input logic eof);
      step_n = 0;
      if (eof) begin
         if (word_held) put_char(word_char, word_first, 1'b1, KIND_WORD);
         if (op_held && step_n < 2) put_char(op_char, 1'b1, 1'b1, KIND_SINGLE);
         word_char  = '0;
         word_held  = 1'b0;
         word_first = 1'b0;
         op_char    = '0;
         op_held    = 1'b0;
         cur_line   = LINE_FIRST;
      end else if (word_held) begin
         if (!blank(b) && !delim(b)) begin
            put_char(word_char, word_first, 1'b0, KIND_WORD);
            word_char  = b;
            word_first = 1'b0;
         end else begin
            put_char(word_char, word_first, 1'b1, KIND_WORD);
            word_held  = 1'b0;
            word_first = 1'b0;
            op_held    = 1'b0;
            take_byte(b);
         end
      end else if (op_held) begin
         op_held = 1'b0;
         if (pairs_up(op_char, b)) begin
            put_char(op_char, 1'b1, 1'b0, KIND_PAIR);
            put_char(b, 1'b0, 1'b1, KIND_PAIR);
         end else begin
            put_char(op_char, 1'b1, 1'b1, KIND_SINGLE);
            take_byte(b);
         end
      end else begin
         take_byte(b);
      end
      if (step_n > 0) token_q[token_q.size()-1].run_last = 1'b1;
   endfunction

   always @(posedge clock) begin
      tok_char_type want;
      tok_char_type got;
      if (reset) begin
         token_q.delete();
         word_char      = '0;
         word_held      = 1'b0;
         word_first     = 1'b0;
         op_char        = '0;
         op_held        = 1'b0;
         cur_line       = LINE_FIRST;
         mismatch_count = 0;
         chars_checked  = 0;
      end else begin
         if (req_valid && req_ready) lex_item(req_in_char, req_end_of_file);
         if (rsp_valid && rsp_ready) begin
            got = '{ch: rsp_token_char, first: rsp_token_first, last: rsp_token_last,
                    kind: rsp_token_kind, line: rsp_line_number, run_last: rsp_run_last};
            if (token_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"%t unexpected token char %h first %b last %b kind %0d",
                            " line %0d run_last %b"},
                           $realtime, got.ch, got.first, got.last, got.kind, got.line,
                           got.run_last);
            end else begin
               want = token_q.pop_front();
               chars_checked++;
               if (want !== got) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%t token mismatch: expected char %h first %b last %b kind %0d",
                               " line %0d run_last %b, got char %h first %b last %b kind %0d",
                               " line %0d run_last %b"},
                              $realtime, want.ch, want.first, want.last, want.kind, want.line,
                              want.run_last, got.ch, got.first, got.last, got.kind, got.line,
                              got.run_last);
               end
            end
         end
      end
      tokens_awaited <= token_q.size();
   end

endmodule

// ----- verif/tb_char_stream_tokenizer.sv -----
`timescale 1ns / 1ps

module tb_char_stream_tokenizer;
   import cst_pkg::*;

   localparam int LINE_BITS      = 16;
   // cycles without any handshake on either side before the run is abandoned
   localparam int QUIET_LIMIT    = 5000;
   localparam int ITEMS_PER_PHASE = 400;
   // a long stretch of blank lines, well past what an 8-bit count could hold
   localparam int LINE_RUN       = 300;

   // delimiters that never open a pair, and the five two-character operators
   localparam logic [12*8-1:0] SINGLE_CHARS = ";,\"+-*/=[]()";
   localparam logic [5*16-1:0] PAIR_CHARS   = {":=", "<=", "<>", ">=", ".."};
   localparam logic [4*8-1:0]  OPEN_CHARS   = {CH_COLON, CH_LT, CH_GT, CH_DOT};
   localparam logic [4*8-1:0]  BLANK_CHARS  = {CH_SPACE, CH_TAB, CH_NUL, CH_NL};

   logic clock;
   logic reset;

   int items_sent;
   int eof_sent;
   int send_idle_pct;
   int rsp_stall_pct;
   int rsp_hold_len;

   int mismatch_count;
   int tokens_awaited;
   int chars_checked;

   cst_req_if                         req_if (clock);
   cst_rsp_if #(.LINE_BITS(LINE_BITS)) rsp_if (clock);

   char_stream_tokenizer #(
      .LINE_BITS(LINE_BITS)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   // The checker watches both channels on its own, predicts every token
   // character and hands back its error tally and how much it still awaits.
   cst_tokenizer_checker #(
      .LINE_BITS(LINE_BITS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_in_char    (req_if.in_char),
      .req_end_of_file(req_if.end_of_file),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_token_char (rsp_if.token_char),
      .rsp_token_first(rsp_if.token_first),
      .rsp_token_last (rsp_if.token_last),
      .rsp_token_kind (rsp_if.token_kind),
      .rsp_line_number(rsp_if.line_number),
      .rsp_run_last   (rsp_if.run_last),
      .mismatch_count (mismatch_count),
      .tokens_awaited (tokens_awaited),
      .chars_checked  (chars_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offer one item and hold it until the block takes it. Drop valid for
   // idle cycles first, each one drawn at the current phase's idle rate.
   task automatic send_item(input logic [7:0] ch, input logic eof);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.in_char     <= ch;
      req_if.end_of_file <= eof;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
      if (eof) eof_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   task automatic send_eof();
      send_item(8'($urandom_range(255)), 1'b1);
   endtask

   // Stop offering and wait until every predicted token character is back.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (tokens_awaited != 0) @(posedge clock);
   endtask

   // A byte that neither separates nor delimits: letters, digits, the top
   // half of the byte range and a few control characters such as CR.
   function automatic logic [7:0] word_byte();
      logic [7:0] pick;
      case ($urandom_range(3))
         0:       pick = 8'("a" + $urandom_range(25));
         1:       pick = 8'("0" + $urandom_range(9));
         2:       pick = 8'($urandom_range(8'h80, 8'hFF));
         default: begin
            case ($urandom_range(4))
               0:       pick = 8'h0D;
               1:       pick = 8'h01;
               2:       pick = 8'h7F;
               3:       pick = "_";
               default: pick = "A" + 8'($urandom_range(25));
            endcase
         end
      endcase
      return pick;
   endfunction

   // One piece of source text. Mostly well-formed words, blanks, delimiters and
   // operators, with broken operators, stray bytes and end-of-file mixed in.
   task automatic send_fragment();
      int pick;
      int n;
      logic [15:0] pair;
      pick = $urandom_range(99);
      if (pick < 30) begin
         n = $urandom_range(1, 6);
         repeat (n) send_item(word_byte(), 1'b0);
      end else if (pick < 44) begin
         send_item(SINGLE_CHARS[$urandom_range(11)*8 +: 8], 1'b0);
      end else if (pick < 60) begin
         pair = PAIR_CHARS[$urandom_range(4)*16 +: 16];
         send_item(pair[15:8], 1'b0);
         send_item(pair[7:0], 1'b0);
      end else if (pick < 68) begin
         // an operator start followed by whatever comes
         send_item(OPEN_CHARS[$urandom_range(3)*8 +: 8], 1'b0);
         if ($urandom_range(1)) send_item(8'($urandom_range(255)), 1'b0);
         else send_item(OPEN_CHARS[$urandom_range(3)*8 +: 8], 1'b0);
      end else if (pick < 88) begin
         n = $urandom_range(1, 3);
         repeat (n) send_item(BLANK_CHARS[$urandom_range(3)*8 +: 8], 1'b0);
      end else if (pick < 96) begin
         send_item(8'($urandom_range(255)), 1'b0);
      end else begin
         send_eof();
      end
   endtask

   // Receiver: random back-pressure at the phase's rate, or one long hold-off
   // when the stimulus asks for it, counted here in cycles.
   initial begin : rsp_drive
      int hold;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_len > 0) begin
            hold         = rsp_hold_len;
            rsp_hold_len = 0;
            rsp_if.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Abandon the run when neither channel moves for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("tb_char_stream_tokenizer: FAIL");
      $finish;
   end

   initial begin : stimulus
      int send_idle_by_phase[4];
      int rsp_stall_by_phase[4];
      int target;
      send_idle_by_phase = '{0, 50, 0, 21};
      rsp_stall_by_phase = '{0, 0, 50, 21};
      items_sent    = 0;
      eof_sent      = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_len  = 0;

      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.in_char     <= '0;
      req_if.end_of_file <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a word and a lone delimiter, every two-character operator,
      // a run of three dots, a dot broken by a tab, the byte extremes, CR as
      // a word byte, NUL and newline as separators, and end-of-file with a
      // held word, with a held operator start and with nothing held.
      send_text("ab;:=<>");
      send_text("<=>=...\t");
      send_item(8'hFF, 1'b0);
      send_item(8'h0D, 1'b0);
      send_item(CH_NUL, 1'b0);
      send_item(CH_NL, 1'b0);
      send_text("x");
      send_eof();
      send_text("<");
      send_eof();
      send_eof();
      drain();

      // Run the line count far up with blank lines, show tokens there, then
      // let end-of-file bring it back to one.
      repeat (LINE_RUN) send_item(CH_NL, 1'b0);
      send_text("w;");
      send_item(CH_NL, 1'b0);
      send_text("v.");
      send_eof();
      send_text("z ");
      drain();

      // Random text over four idling phases, each ended by a full drain.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = send_idle_by_phase[ph];
         rsp_stall_pct = rsp_stall_by_phase[ph];
         target        = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target) send_fragment();
         if (ph == 0) begin
            // hold the receiver off and keep feeding operators so the result
            // queue fills and the block stalls its input
            rsp_hold_len = 80;
            repeat (10) send_text(":=");
         end
         drain();
      end

      // let any stray late result show up before the verdict
      repeat (16) @(posedge clock);

      $display("Covered %0d items (%0d end-of-file) and %0d checked token characters,",
               items_sent, eof_sent, chars_checked);
      $display("across a long run of blank lines, a long receiver hold-off and four idling phases.");
      if (mismatch_count == 0 && tokens_awaited == 0) begin
         $display("tb_char_stream_tokenizer: PASS");
      end else begin
         $display("%0d mismatches, %0d token characters never arrived",
                  mismatch_count, tokens_awaited);
         $display("tb_char_stream_tokenizer: FAIL");
      end
      $finish;
   end

endmodule
